// ----- sv/bawm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bawm_pkg
// Shared types, field widths and the microcode program of the block average
// core.
// ----------------------------------------------------------------------------
package bawm_pkg;

    localparam int CFG_W    = 13;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 28;
    localparam int AVG_W    = 24;
    localparam int BLK_W    = 16;
    localparam int OUT_W    = 2 * AVG_W + BLK_W;
    localparam int STEP_W   = 4;

    localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(60);

    localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W - 1){1'b1}}};
    localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W - 1){1'b0}}};

    typedef logic [STEP_W-1:0] step_t;

    // jump conditions: when true go to target, else fall through (or return to ST_WAIT on ret)
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NO_BLOCK,
        COND_DIV_MORE,
        COND_OUT_FULL
    } cond_t;

    typedef enum logic {
        DIV_SRC_SUM,
        DIV_SRC_MAX
    } div_src_t;

    typedef struct packed {
        logic     in_ready;
        logic     acc_en;
        logic     max_en;
        logic     div_load;
        div_src_t div_src;
        logic     div_step;
        logic     store_avg;
        logic     store_max;
        logic     clr_block;
        logic     emit;
        cond_t    cond;
        step_t    target;
        logic     ret;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic no_block;
        logic div_more;
        logic out_full;
    } status_t;

    localparam step_t ST_WAIT    = STEP_W'(0);
    localparam step_t ST_ACC     = STEP_W'(1);
    localparam step_t ST_MAX     = STEP_W'(2);
    localparam step_t ST_LOAD_A  = STEP_W'(3);
    localparam step_t ST_DIV_A   = STEP_W'(4);
    localparam step_t ST_STORE_A = STEP_W'(5);
    localparam step_t ST_LOAD_M  = STEP_W'(6);
    localparam step_t ST_DIV_M   = STEP_W'(7);
    localparam step_t ST_STORE_M = STEP_W'(8);
    localparam step_t ST_EMIT    = STEP_W'(9);

    // Microcode ROM: one control word per step.
    function automatic ctrl_t ucode(step_t step);
        ctrl_t w;
        w        = '0;
        w.cond   = COND_NONE;
        w.target = ST_WAIT;
        unique case (step)
            ST_WAIT:
            begin
                w.in_ready = 1'b1;
                w.cond     = COND_NO_INPUT;
                w.target   = ST_WAIT;
            end
            ST_ACC:
            begin
                w.acc_en = 1'b1;
                w.cond   = COND_NO_BLOCK;
                w.target = ST_WAIT;
            end
            ST_MAX:
            begin
                w.max_en = 1'b1;
            end
            ST_LOAD_A:
            begin
                w.div_load = 1'b1;
                w.div_src  = DIV_SRC_SUM;
            end
            ST_DIV_A:
            begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_MORE;
                w.target   = ST_DIV_A;
            end
            ST_STORE_A:
            begin
                w.store_avg = 1'b1;
            end
            ST_LOAD_M:
            begin
                w.div_load = 1'b1;
                w.div_src  = DIV_SRC_MAX;
            end
            ST_DIV_M:
            begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_MORE;
                w.target   = ST_DIV_M;
            end
            ST_STORE_M:
            begin
                w.store_max = 1'b1;
                w.clr_block = 1'b1;
            end
            ST_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FULL;
                w.target = ST_EMIT;
                w.ret    = 1'b1;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- sv/bawm_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bawm_divider
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module bawm_divider #(
    parameter int DVD_W = 36,
    parameter int DIV_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             step,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             last
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [CNT_W-1:0] iter_reg;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_diff;
    logic             ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        ge        = rem_shift >= {1'b0, divisor};
        // remainder stays below the divisor, so the difference fits
        rem_next  = ge ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        quo_next  = {quo_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (load)
        begin
            iter_reg <= CNT_W'(DVD_W);
        end
        else if (step && iter_reg != '0)
        begin
            iter_reg <= iter_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = iter_reg == CNT_W'(1);

endmodule
`default_nettype wire

// ----- sv/bawm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bawm_datapath
// Block accumulator, running maximum, divider and output word register,
// driven by the control word of the sequencer.
// ----------------------------------------------------------------------------
module bawm_datapath #(
    parameter int MAX_WINDOW    = 4096,
    parameter int FRACTION_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bawm_pkg::ctrl_t              ctrl,
    output bawm_pkg::status_t            status,
    input  logic                         cfg_valid,
    input  logic [bawm_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    input  logic [bawm_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                         in_start,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bawm_pkg::OUT_W-1:0]   out_data
);

    import bawm_pkg::*;

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int DVD_W = SUM_W + FRACTION_BITS;
    localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(AVG_MAX);
    localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1) << (AVG_W - 1);

    logic [CFG_W-1:0]    win_cfg_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                start_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [WIN_W-1:0]    count_reg;
    logic [WIN_W-1:0]    count_next;
    logic [SUM_W-1:0]    max_sum_reg;
    logic                have_max_reg;
    logic [BLK_W-1:0]    blocks_reg;
    logic [BLK_W-1:0]    number_reg;
    logic                neg_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [AVG_W-1:0]    max_avg_reg;
    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;

    logic [31:0]         cfg_ext;
    logic [31:0]         win_ext;
    logic [WIN_W-1:0]    win;
    logic [SUM_W-1:0]    div_src_val;
    logic [SUM_W-1:0]    div_mag;
    logic [DVD_W-1:0]    dividend;
    logic [DVD_W-1:0]    quotient;
    logic [DVD_W-1:0]    quo_neg;
    logic                div_last;
    logic [AVG_W-1:0]    sat_avg;
    logic                in_fire;
    logic                out_load;
    logic                out_full;

    // clamp the window into 1..MAX_WINDOW
    always_comb
    begin
        cfg_ext = 32'(win_cfg_reg);
        priority if (cfg_ext == 32'd0)
        begin
            win_ext = 32'd1;
        end
        else if (cfg_ext > 32'(MAX_WINDOW))
        begin
            win_ext = 32'(MAX_WINDOW);
        end
        else
        begin
            win_ext = cfg_ext;
        end
        win = win_ext[WIN_W-1:0];
    end

    always_comb
    begin
        sum_next   = (start_reg ? '0 : sum_reg)
                   + {{(SUM_W - SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        count_next = (start_reg ? '0 : count_reg) + WIN_W'(1);
    end

    always_comb
    begin
        div_src_val = (ctrl.div_src == DIV_SRC_MAX) ? max_sum_reg : sum_reg;
        div_mag     = div_src_val[SUM_W-1] ? SUM_W'(0) - div_src_val : div_src_val;
        dividend    = DVD_W'(div_mag) << FRACTION_BITS;
    end

    bawm_divider #(
        .DVD_W (DVD_W),
        .DIV_W (WIN_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ctrl.div_load),
        .step     (ctrl.div_step),
        .dividend (dividend),
        .divisor  (win),
        .quotient (quotient),
        .last     (div_last)
    );

    // sign the quotient and saturate to the average range
    always_comb
    begin
        quo_neg = DVD_W'(0) - quotient;
        if (!neg_reg)
        begin
            sat_avg = (quotient > POS_LIM) ? AVG_MAX : quotient[AVG_W-1:0];
        end
        else
        begin
            sat_avg = (quotient > NEG_LIM) ? AVG_MIN : quo_neg[AVG_W-1:0];
        end
    end

    assign in_fire  = ctrl.in_ready && in_valid;
    assign out_full = out_valid_reg && !out_ready;
    assign out_load = ctrl.emit && !out_full;

    always_comb
    begin
        status.no_input = !in_valid;
        status.no_block = count_next < win;
        status.div_more = !div_last;
        status.out_full = out_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cfg_reg   <= WIN_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            max_sum_reg   <= '0;
            have_max_reg  <= 1'b0;
            blocks_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                win_cfg_reg <= cfg_data;
            end
            if (ctrl.acc_en)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                if (start_reg)
                begin
                    max_sum_reg  <= '0;
                    have_max_reg <= 1'b0;
                    blocks_reg   <= '0;
                end
            end
            if (ctrl.max_en)
            begin
                if (!have_max_reg || $signed(sum_reg) > $signed(max_sum_reg))
                begin
                    max_sum_reg  <= sum_reg;
                    have_max_reg <= 1'b1;
                end
                if (blocks_reg != '1)
                begin
                    blocks_reg <= blocks_reg + BLK_W'(1);
                end
            end
            if (ctrl.clr_block)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= in_sample;
            start_reg  <= in_start;
        end
        if (ctrl.max_en)
        begin
            number_reg <= blocks_reg;
        end
        if (ctrl.div_load)
        begin
            neg_reg <= div_src_val[SUM_W-1];
        end
        if (ctrl.store_avg)
        begin
            avg_reg <= sat_avg;
        end
        if (ctrl.store_max)
        begin
            max_avg_reg <= sat_avg;
        end
        if (out_load)
        begin
            out_data_reg <= {number_reg, max_avg_reg, avg_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ----- sv/bawm_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bawm_sequencer
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module bawm_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  bawm_pkg::status_t status,
    output bawm_pkg::ctrl_t   ctrl
);

    import bawm_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NONE:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = status.no_input;
            COND_NO_BLOCK: take = status.no_block;
            COND_DIV_MORE: take = status.div_more;
            COND_OUT_FULL: take = status.out_full;
            default:       take = 1'b1;
        endcase
        priority if (take)
        begin
            step_next = ctrl.target;
        end
        else if (ctrl.ret)
        begin
            step_next = ST_WAIT;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/block_average_with_max_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_average_with_max_core
// Non-overlapping block average decimator with a running maximum.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_data write the window length (samples per block); cfg_ready
//   is always high. Write it only while the core is idle.
//   The input stream carries one sample per word; tuser marks the first
//   sample of a series, which clears the partial block, maximum and counter.
//   The output stream carries one word per completed block: block average,
//   maximum average (both 8 fraction bits by default) and block number.
// Steps:
//   A sample that does not complete a block is accepted, then added.
//   A completing sample also updates the maximum, then runs the
//   one-bit-per-step divider once for each average, block then maximum; the
//   word appears on the output the cycle after the emit step.
// Reset: window length returns to 60, sums, maximum and counter clear.
// Stall: the output register holds a word until taken; the core keeps taking
//   samples and waits in its emit step only if a second result is ready.
// ----------------------------------------------------------------------------
module block_average_with_max_core #(
    parameter int MAX_WINDOW    = 4096,
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bawm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bawm_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample
    input  logic                          s_axis_tuser,  // [0] start_series
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [23:0] block_average, [47:24] max_average, [63:48] block_number
    output logic [bawm_pkg::OUT_W-1:0]    m_axis_tdata
);

    import bawm_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    bawm_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    bawm_datapath #(
        .MAX_WINDOW    (MAX_WINDOW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_sample (s_axis_tdata),
        .in_start  (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = ctrl.in_ready;

endmodule
`default_nettype wire

// ----- verif/tb_block_average_with_max_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_average_with_max_core
// Self-checking bench for the block average decimator with running maximum.
// Streams samples under many window lengths, including the clamped extremes,
// a window change inside a block and series restarts. A scoreboard predicts
// every block word and compares each output word field by field.
// ----------------------------------------------------------------------------
module tb_block_average_with_max_core;
    import bawm_pkg::*;

    localparam int FRAC        = 8;
    localparam int WIN_CAP     = 4096;
    localparam int SETTLE      = 100;
    localparam int HOLD_CYCLES = 1500;
    localparam int QUIET_LIMIT = 20000;
    localparam int PRINT_CAP   = 30;

    typedef struct {
        logic [AVG_W-1:0] mean;
        logic [AVG_W-1:0] peak;
        logic [BLK_W-1:0] index;
    } block_word_t;

    class block_scoreboard;
        logic [CFG_W-1:0]        window;
        logic signed [SUM_W-1:0] acc_sum;
        int unsigned             acc_count;
        logic signed [SUM_W-1:0] peak_sum;
        bit                      have_peak;
        logic [BLK_W-1:0]        blocks;
        block_word_t             pending[$];
        int unsigned             errors;
        int unsigned             samples;
        int unsigned             checked;

        function new();
            window    = WIN_RESET;
            acc_sum   = '0;
            acc_count = 0;
            peak_sum  = '0;
            have_peak = 1'b0;
            blocks    = '0;
            errors    = 0;
            samples   = 0;
            checked   = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] value);
            window = value;
        endfunction

        // sum * 2^FRAC / span, truncated toward zero, clipped to 24 bits
        function logic [AVG_W-1:0] scaled_mean(logic signed [SUM_W-1:0] total,
                                               int unsigned span);
            longint q;
            longint top;
            top = (longint'(1) <<< (AVG_W - 1)) - 1;
            q   = (longint'(total) * (longint'(1) <<< FRAC)) / longint'(span);
            if (q > top)
                q = top;
            if (q < -top - 1)
                q = -top - 1;
            return q[AVG_W-1:0];
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] smp, logic first);
            int unsigned span;
            block_word_t w;
            span = (window == 0) ? 1 : ((window > WIN_CAP) ? WIN_CAP : window);
            samples++;
            if (first)
            begin
                acc_sum   = '0;
                acc_count = 0;
                peak_sum  = '0;
                have_peak = 1'b0;
                blocks    = '0;
            end
            acc_sum = acc_sum + SUM_W'(signed'(smp));
            acc_count++;
            if (acc_count >= span)
            begin
                if (!have_peak || acc_sum > peak_sum)
                begin
                    peak_sum  = acc_sum;
                    have_peak = 1'b1;
                end
                w.mean  = scaled_mean(acc_sum, span);
                w.peak  = scaled_mean(peak_sum, span);
                w.index = blocks;
                if (blocks != '1)
                    blocks++;
                pending.push_back(w);
                acc_sum   = '0;
                acc_count = 0;
            end
        endfunction

        task check_result(logic [OUT_W-1:0] word);
            block_word_t w;
            if (pending.size() == 0)
                report($sformatf("output word %h with no block pending", word));
            else
            begin
                w = pending.pop_front();
                checked++;
                if (word[AVG_W-1:0] !== w.mean)
                    report($sformatf("block %0d average %h, want %h",
                                     w.index, word[AVG_W-1:0], w.mean));
                if (word[2*AVG_W-1:AVG_W] !== w.peak)
                    report($sformatf("block %0d max average %h, want %h",
                                     w.index, word[2*AVG_W-1:AVG_W], w.peak));
                if (word[OUT_W-1:2*AVG_W] !== w.index)
                    report($sformatf("block number %0d, want %0d",
                                     word[OUT_W-1:2*AVG_W], w.index));
            end
        endtask

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP)
                $display("MISMATCH: %s", what);
        endtask
    endclass

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    int snd_idle_pct = 26;
    int rcv_idle_pct = 47;
    int hold_asks    = 0;

    block_scoreboard board;

    block_average_with_max_core #(
        .MAX_WINDOW    (WIN_CAP),
        .FRACTION_BITS (FRAC)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic first);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_sample(smp, first);
    endtask

    // start a series and feed the same value n times
    task automatic push_run(input logic [SAMPLE_W-1:0] smp, input int n);
        for (int i = 0; i < n; i++)
            push_sample(smp, i == 0);
    endtask

    // drain pending blocks, then give the core time to finish its last sample
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_window(value);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2, 3:    v = SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic run_random(input int count, input int start_pct);
        for (int i = 0; i < count; i++)
            push_sample(pick_sample(), $urandom_range(99) < start_pct);
        settle();
    endtask

    // output side: check each word, stall at random or for a long hold
    initial
    begin : sink_side
        int held;
        int seen;
        held = 0;
        seen = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if (hold_asks != seen)
            begin
                seen = hold_asks;
                held = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                m_axis_tready <= 1'b0;
                held--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TIMEOUT: no word accepted for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : main_flow
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window left at its reset length
        run_random(121, 0);

        // one-sample blocks: extremes, a negative block that must not win
        write_window(CFG_W'(1));
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b0);
        settle();

        // zero window acts as one; a negative first block is still taken
        write_window(CFG_W'(0));
        push_sample(16'h8000, 1'b1);
        push_sample(16'hC000, 1'b0);
        settle();

        // shrink the window inside a block: completes at once, saturates
        write_window(CFG_W'(8));
        push_run(16'h7FFF, 5);
        settle();
        write_window(CFG_W'(2));
        push_sample(16'h7FFF, 1'b0);
        settle();

        // series restart drops the partial block
        write_window(CFG_W'(3));
        push_sample(16'h1234, 1'b0);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'h0042, 1'b1);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b0);
        settle();

        // top register value clamps to the largest window, so no block yet;
        // a shrink then closes the block and saturates low
        write_window('1);
        push_run(16'h8000, 40);
        settle();
        write_window(CFG_W'(2));
        push_sample(16'h8000, 1'b0);
        settle();

        write_window(CFG_W'($urandom_range(12)));
        run_random(200, 3);

        snd_idle_pct = 47;
        rcv_idle_pct = 26;
        // partial block under the largest window, closed by the next window
        write_window(CFG_W'(WIN_CAP));
        push_run(16'h7FFF, 20);
        settle();
        write_window(CFG_W'($urandom_range(12)));
        run_random(200, 3);
        write_window(CFG_W'($urandom_range(12)));
        run_random(200, 3);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // hold the output off while one-sample blocks keep coming
        write_window(CFG_W'(1));
        hold_asks++;
        run_random(200, 3);
        write_window(CFG_W'($urandom_range(12)));
        run_random(200, 3);

        if (board.pending.size() != 0)
            board.report($sformatf("%0d block words never arrived", board.pending.size()));
        $display("Summary: %0d samples sent, %0d block words checked", board.samples,
                 board.checked);
        $display("Summary: windows 0..12 and 60, partial blocks under 4096 and 8191,"
                 , " mid-block change, restarts, saturation and a long output stall");
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
